>>> design/fnal_pkg.sv
// Shared types and constants for the five-neighbour layer-step automaton.
// Holds cube geometry, op and result codes and the item and result beat structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fnal_pkg;

    // Cube geometry: the cube is cut into cubic chunks of CHUNK_EDGE cells per edge.
    localparam int CHUNK_EDGE      = 8;
    localparam int CHUNKS_PER_SIDE = 4;
    localparam int SIDE            = CHUNK_EDGE * CHUNKS_PER_SIDE;
    localparam int SIDE_BITS       = $clog2(SIDE);
    localparam int CPS_BITS        = $clog2(CHUNKS_PER_SIDE);
    localparam int ROWS            = SIDE * SIDE;
    localparam int ADDR_BITS       = 2 * SIDE_BITS;
    localparam int NUM_CHUNKS      = CHUNKS_PER_SIDE * CHUNKS_PER_SIDE * CHUNKS_PER_SIDE;
    localparam int NUM_COLS        = CHUNKS_PER_SIDE * CHUNKS_PER_SIDE;
    localparam int IDX_BITS        = 3 * CPS_BITS;

    // Op codes of an input beat.
    localparam logic [1:0] OP_STEP  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_NOTICE = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_QUIET  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic [4:0] cell_z;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] chunk_x;
        logic [1:0] chunk_y;
        logic [1:0] chunk_z;
        logic       cell_value;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

>>> design/five_neighbour_automaton_layer_step.sv
// Top level of the five-neighbour layer-step automaton: sequencer, cube memory,
// row rule unit and notice scanner in one module.
// Depends on fnal_pkg.
//
//  Channel   Direction  Handshake               Payload
//  item      in         item_valid/item_stall   fnal_pkg::item_t
//  result    out        result_valid/result_stall fnal_pkg::result_t
//  rule      in         rule_we                 rule_data (32 bits)
//
// A step makes one pass over the current layer at one row of 32 cells a cycle,
// with wrap-around, then scans the chunk columns at one a cycle up to the last
// changed one, or gives a quiet beat if none changed; a marked column waits for
// a free output slot. A clear sweeps all 1024 rows and then scans 64 chunks; a
// read goes through S_READ and S_READOUT. After reset a clearing pass sets up
// the cube; no item is taken during it. The block takes a new item only when
// idle; a held result beat stalls the scanner but not the memory pass.
`timescale 1ns / 1ps
`default_nettype none

module five_neighbour_automaton_layer_step (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire fnal_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output fnal_pkg::result_t      result,
    input  wire logic              rule_we,
    input  wire logic [31:0]       rule_data
);
    import fnal_pkg::*;

    typedef enum logic [6:0] {
        S_SWEEP   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_STEP    = 7'b0000100,
        S_EMIT    = 7'b0001000,
        S_TAIL    = 7'b0010000,
        S_READ    = 7'b0100000,
        S_READOUT = 7'b1000000
    } state_t;

    localparam logic [ADDR_BITS:0] SWEEP_END = (ADDR_BITS + 1)'(ROWS);
    localparam logic [ADDR_BITS:0] STEP_LAST = (ADDR_BITS + 1)'(SIDE + 1);
    localparam logic [ADDR_BITS:0] STEP_END  = (ADDR_BITS + 1)'(SIDE + 2);

    // Control state.
    state_t                  state_reg, state_next;
    logic                    mode_clear_reg, mode_clear_next;
    logic [ADDR_BITS:0]      cnt_reg, cnt_next;
    logic [ADDR_BITS:0]      cnt_d_reg, cnt_d_next;
    logic                    issue_d_reg, issue_d_next;
    logic [SIDE_BITS-1:0]    layer_offset_reg, layer_offset_next;
    logic [31:0]             rule_word_reg;
    logic [NUM_COLS-1:0]     col_changed_reg, col_changed_next;
    logic [NUM_CHUNKS-1:0]   touched_reg, touched_next;
    logic [NUM_CHUNKS-1:0]   pending_reg, pending_next;
    logic [IDX_BITS-1:0]     idx_reg, idx_next;
    logic                    tail_quiet_reg, tail_quiet_next;
    logic                    result_valid_reg, result_valid_next;

    // Payload state.
    logic [SIDE-1:0]         win1_reg, win1_next;
    logic [SIDE-1:0]         win2_reg, win2_next;
    logic [ADDR_BITS-1:0]    rd_addr_reg, rd_addr_next;
    logic [SIDE_BITS-1:0]    rd_x_reg, rd_x_next;
    result_t                 result_reg, result_next;

    // Cube memory: one row of SIDE cells per word, addressed by {z, y}.
    logic [SIDE-1:0]         cube_mem [ROWS];
    logic [SIDE-1:0]         rd_a_reg, rd_b_reg;
    logic [ADDR_BITS-1:0]    rd_addr_a, rd_addr_b, wr_addr;
    logic [SIDE-1:0]         wr_data;
    logic                    wr_en;

    // Datapath signals.
    logic [SIDE_BITS-1:0]    layer_next_z;
    logic [SIDE_BITS-1:0]    row_y;
    logic [SIDE-1:0]         new_row;
    logic [SIDE-1:0]         row_diff;
    logic [NUM_COLS-1:0]     col_touch;
    logic [NUM_CHUNKS-1:0]   row_touch;
    logic                    slot_free;
    logic                    rest_set;
    logic                    idx_final;

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign slot_free    = !result_valid_reg || !result_stall;
    assign layer_next_z = layer_offset_reg + 1'b1;
    assign row_y        = cnt_d_reg[SIDE_BITS-1:0] - SIDE_BITS'(2);
    assign rest_set     = |((pending_reg >> idx_reg) >> 1);
    assign idx_final    = (idx_reg == IDX_BITS'(NUM_CHUNKS - 1));

    // Rule unit: one new row from the rows above, at and below, one cell per lane.
    always_comb
    begin
        for (int x = 0; x < SIDE; x++)
        begin
            new_row[x] = rule_word_reg[{win2_reg[(x + SIDE - 1) % SIDE],
                                        win2_reg[(x + 1) % SIDE],
                                        win1_reg[x], rd_a_reg[x], win2_reg[x]}];
        end
    end

    assign row_diff = new_row ^ rd_b_reg;

    // Chunk columns whose cells change in the row being written.
    always_comb
    begin
        col_touch = '0;
        for (int cx = 0; cx < CHUNKS_PER_SIDE; cx++)
        begin
            col_touch[{CPS_BITS'(cx), row_y[SIDE_BITS-1 -: CPS_BITS]}] =
                |row_diff[cx * CHUNK_EDGE +: CHUNK_EDGE];
        end
    end

    // Chunks that hold an active cell in the row returned by the clear sweep.
    always_comb
    begin
        row_touch = '0;
        for (int cx = 0; cx < CHUNKS_PER_SIDE; cx++)
        begin
            row_touch[{CPS_BITS'(cx),
                       cnt_d_reg[SIDE_BITS-1 -: CPS_BITS],
                       cnt_d_reg[ADDR_BITS-1 -: CPS_BITS]}] =
                |rd_a_reg[cx * CHUNK_EDGE +: CHUNK_EDGE];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        mode_clear_next   = mode_clear_reg;
        cnt_next          = cnt_reg;
        cnt_d_next        = cnt_reg;
        issue_d_next      = 1'b0;
        layer_offset_next = layer_offset_reg;
        col_changed_next  = col_changed_reg;
        touched_next      = touched_reg;
        pending_next      = pending_reg;
        idx_next          = idx_reg;
        tail_quiet_next   = tail_quiet_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        rd_addr_next      = rd_addr_reg;
        rd_x_next         = rd_x_reg;
        win1_next         = win1_reg;
        win2_next         = win2_reg;
        rd_addr_a         = '0;
        rd_addr_b         = '0;
        wr_en             = 1'b0;
        wr_addr           = '0;
        wr_data           = '0;

        // The row window moves on with every row the memory returns.
        if (issue_d_reg)
        begin
            win1_next = win2_reg;
            win2_next = rd_a_reg;
        end

        unique case (state_reg)
            S_SWEEP:
            begin
                // Zero each row, set the origin cell, and, for a clear, note the chunks that held cells.
                if (cnt_reg < SWEEP_END)
                begin
                    rd_addr_a    = cnt_reg[ADDR_BITS-1:0];
                    wr_en        = 1'b1;
                    wr_addr      = cnt_reg[ADDR_BITS-1:0];
                    wr_data      = (cnt_reg == '0) ? SIDE'(1) : '0;
                    issue_d_next = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
                if (mode_clear_reg && issue_d_reg)
                begin
                    touched_next = touched_reg | row_touch;
                end
                if (cnt_reg == SWEEP_END)
                begin
                    if (mode_clear_reg)
                    begin
                        state_next        = S_EMIT;
                        pending_next      = touched_next & ~NUM_CHUNKS'(1);
                        idx_next          = '0;
                        tail_quiet_next   = 1'b0;
                        layer_offset_next = '0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.op)
                        OP_STEP:
                        begin
                            state_next       = S_STEP;
                            cnt_next         = '0;
                            col_changed_next = '0;
                        end
                        OP_CLEAR:
                        begin
                            state_next      = S_SWEEP;
                            mode_clear_next = 1'b1;
                            cnt_next        = '0;
                            touched_next    = '0;
                        end
                        OP_READ:
                        begin
                            state_next   = S_READ;
                            rd_addr_next = {item.cell_z[SIDE_BITS-1:0],
                                            item.cell_y[SIDE_BITS-1:0]};
                            rd_x_next    = item.cell_x[SIDE_BITS-1:0];
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_STEP:
            begin
                // Read layer z from row 31 round to row 0, and the old rows of layer z+1.
                if (cnt_reg <= STEP_LAST)
                begin
                    rd_addr_a    = {layer_offset_reg, cnt_reg[SIDE_BITS-1:0] - 1'b1};
                    rd_addr_b    = {layer_next_z, cnt_reg[SIDE_BITS-1:0] - SIDE_BITS'(2)};
                    issue_d_next = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
                // Write one new row once its lower neighbour has arrived.
                if (issue_d_reg && (cnt_d_reg >= (ADDR_BITS + 1)'(2)))
                begin
                    wr_en            = 1'b1;
                    wr_addr          = {layer_next_z, row_y};
                    wr_data          = new_row;
                    col_changed_next = col_changed_reg | col_touch;
                end
                if (cnt_reg == STEP_END)
                begin
                    layer_offset_next = layer_next_z;
                    mode_clear_next   = 1'b0;
                    if (col_changed_next == '0)
                    begin
                        state_next      = S_TAIL;
                        tail_quiet_next = 1'b1;
                    end
                    else
                    begin
                        state_next   = S_EMIT;
                        pending_next = NUM_CHUNKS'(col_changed_next);
                        idx_next     = '0;
                    end
                end
            end

            S_EMIT:
            begin
                // One chunk a cycle; a marked chunk waits for a free output slot.
                if (!pending_reg[idx_reg] || slot_free)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (pending_reg[idx_reg])
                    begin
                        result_valid_next      = 1'b1;
                        result_next.kind       = KIND_NOTICE;
                        result_next.cell_value = 1'b0;
                        if (mode_clear_reg)
                        begin
                            result_next.chunk_x = idx_reg[3*CPS_BITS-1 -: CPS_BITS];
                            result_next.chunk_y = idx_reg[2*CPS_BITS-1 -: CPS_BITS];
                            result_next.chunk_z = idx_reg[CPS_BITS-1:0];
                            result_next.last    = 1'b0;
                        end
                        else
                        begin
                            result_next.chunk_x = idx_reg[2*CPS_BITS-1 -: CPS_BITS];
                            result_next.chunk_y = idx_reg[CPS_BITS-1:0];
                            result_next.chunk_z = layer_offset_reg[SIDE_BITS-1 -: CPS_BITS];
                            result_next.last    = !rest_set;
                        end
                    end
                    if (mode_clear_reg && idx_final)
                    begin
                        state_next = S_TAIL;
                    end
                    else if (!mode_clear_reg && !rest_set)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_TAIL:
            begin
                // Final beat: quiet step result or the origin chunk of a clear.
                if (slot_free)
                begin
                    result_valid_next      = 1'b1;
                    result_next.kind       = tail_quiet_reg ? KIND_QUIET : KIND_NOTICE;
                    result_next.chunk_x    = '0;
                    result_next.chunk_y    = '0;
                    result_next.chunk_z    = '0;
                    result_next.cell_value = 1'b0;
                    result_next.last       = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            S_READ:
            begin
                rd_addr_a  = rd_addr_reg;
                state_next = S_READOUT;
            end

            S_READOUT:
            begin
                // The address is held so that the read data stays put while stalled.
                rd_addr_a = rd_addr_reg;
                if (slot_free)
                begin
                    result_valid_next      = 1'b1;
                    result_next.kind       = KIND_READ;
                    result_next.chunk_x    = '0;
                    result_next.chunk_y    = '0;
                    result_next.chunk_z    = '0;
                    result_next.cell_value = rd_a_reg[rd_x_reg];
                    result_next.last       = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_SWEEP;
            mode_clear_reg   <= 1'b0;
            cnt_reg          <= '0;
            cnt_d_reg        <= '0;
            issue_d_reg      <= 1'b0;
            layer_offset_reg <= '0;
            rule_word_reg    <= '0;
            col_changed_reg  <= '0;
            touched_reg      <= '0;
            pending_reg      <= '0;
            idx_reg          <= '0;
            tail_quiet_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mode_clear_reg   <= mode_clear_next;
            cnt_reg          <= cnt_next;
            cnt_d_reg        <= cnt_d_next;
            issue_d_reg      <= issue_d_next;
            layer_offset_reg <= layer_offset_next;
            col_changed_reg  <= col_changed_next;
            touched_reg      <= touched_next;
            pending_reg      <= pending_next;
            idx_reg          <= idx_next;
            tail_quiet_reg   <= tail_quiet_next;
            result_valid_reg <= result_valid_next;
            if (rule_we)
            begin
                rule_word_reg <= rule_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        win1_reg    <= win1_next;
        win2_reg    <= win2_next;
        rd_addr_reg <= rd_addr_next;
        rd_x_reg    <= rd_x_next;
        result_reg  <= result_next;
    end

    // Cube memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cube_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= cube_mem[rd_addr_a];
        rd_b_reg <= cube_mem[rd_addr_b];
    end

    // A step never overwrites the layer it is reading from.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) && wr_en |-> wr_addr[ADDR_BITS-1 -: SIDE_BITS] != layer_offset_reg)
        else $error("step wrote into its source layer");

    // The step scanner only runs when at least one column changed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && !mode_clear_reg |-> pending_reg != '0)
        else $error("step notice scan started with nothing to report");

    // Only a read beat carries a cell value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (result_reg.kind != KIND_READ) |-> result_reg.cell_value == 1'b0)
        else $error("cell value set on a non-read beat");

    // The final beat from S_TAIL (a quiet step or a clear) closes the item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAIL) && slot_free |=>
            (state_reg == S_IDLE) && result_valid_reg && result_reg.last)
        else $error("final beat did not end the item");

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for five_neighbour_automaton_layer_step.
// Predicts every result beat from its own copy of the cube, layer and rule word
// and checks them in order. Depends on fnal_pkg and the top-level RTL.
`timescale 1ns / 1ps

module testbench;
    import fnal_pkg::*;

    // Op 3 has no meaning; the block must swallow it without a result.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 150;
    localparam int MAX_PRINTED   = 40;
    localparam int PHASE_ITEMS   = 18;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_style_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        rule_we      = 1'b0;
    logic [31:0] rule_data    = '0;

    five_neighbour_automaton_layer_step dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .rule_we      (rule_we),
        .rule_data    (rule_data)
    );

    // Predicted state of the block: cube rows are indexed [z][y], bit x.
    bit [SIDE-1:0] cube_rows [SIDE][SIDE];
    bit [31:0]     rule_model  = '0;
    int unsigned   layer_model = 0;
    result_t       expected_beats[$];
    int            error_count = 0;

    // Sender and receiver pacing.
    int           gap_max     = 0;
    int           burst_left  = 0;
    stall_style_t stall_style = STALL_NONE;
    bit           hold_req    = 1'b0;
    bit           hold_ack    = 1'b0;
    int           hold_left   = 0;
    bit           run_stalling = 1'b0;
    int           run_left    = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic result_t make_beat(logic [1:0] kind, int unsigned cx,
                                          int unsigned cy, int unsigned cz, bit value);
        result_t beat;
        beat.kind       = kind;
        beat.chunk_x    = cx[1:0];
        beat.chunk_y    = cy[1:0];
        beat.chunk_z    = cz[1:0];
        beat.cell_value = value;
        beat.last       = 1'b0;
        return beat;
    endfunction

    // Works out the result beats of one accepted item and updates the model.
    function automatic void predict_item(item_t it);
        result_t     batch[$];
        bit [4:0]    nbhd;
        bit          fresh;
        bit          changed;
        bit          occupied;
        int unsigned zc;
        int unsigned zn;
        int unsigned xp;
        int unsigned xm;
        int unsigned yp;
        int unsigned ym;
        zc = layer_model;
        case (it.op)
            OP_STEP:
            begin
                zn = (zc + 1) % SIDE;
                for (int cx = 0; cx < CHUNKS_PER_SIDE; cx++)
                begin
                    for (int cy = 0; cy < CHUNKS_PER_SIDE; cy++)
                    begin
                        changed = 1'b0;
                        for (int x = cx * CHUNK_EDGE; x < (cx + 1) * CHUNK_EDGE; x++)
                        begin
                            for (int y = cy * CHUNK_EDGE; y < (cy + 1) * CHUNK_EDGE; y++)
                            begin
                                xp = (x + 1) % SIDE;
                                xm = (x + SIDE - 1) % SIDE;
                                yp = (y + 1) % SIDE;
                                ym = (y + SIDE - 1) % SIDE;
                                nbhd = {cube_rows[zc][y][xm], cube_rows[zc][y][xp],
                                        cube_rows[zc][ym][x], cube_rows[zc][yp][x],
                                        cube_rows[zc][y][x]};
                                fresh = rule_model[nbhd];
                                if (fresh != cube_rows[zn][y][x])
                                begin
                                    cube_rows[zn][y][x] = fresh;
                                    changed = 1'b1;
                                end
                            end
                        end
                        if (changed)
                            batch.push_back(make_beat(KIND_NOTICE, cx, cy, zn / CHUNK_EDGE, 1'b0));
                    end
                end
                if (batch.size() == 0)
                    batch.push_back(make_beat(KIND_QUIET, 0, 0, 0, 1'b0));
                layer_model = zn;
            end
            OP_CLEAR:
            begin
                // Every occupied chunk but the origin one, then the origin chunk last.
                for (int cx = 0; cx < CHUNKS_PER_SIDE; cx++)
                begin
                    for (int cy = 0; cy < CHUNKS_PER_SIDE; cy++)
                    begin
                        for (int cz = 0; cz < CHUNKS_PER_SIDE; cz++)
                        begin
                            occupied = 1'b0;
                            for (int z = cz * CHUNK_EDGE; z < (cz + 1) * CHUNK_EDGE; z++)
                            begin
                                for (int y = cy * CHUNK_EDGE; y < (cy + 1) * CHUNK_EDGE; y++)
                                begin
                                    if (cube_rows[z][y][cx * CHUNK_EDGE +: CHUNK_EDGE] != 0)
                                        occupied = 1'b1;
                                end
                            end
                            if (occupied && (cx != 0 || cy != 0 || cz != 0))
                                batch.push_back(make_beat(KIND_NOTICE, cx, cy, cz, 1'b0));
                        end
                    end
                end
                for (int z = 0; z < SIDE; z++)
                begin
                    for (int y = 0; y < SIDE; y++)
                        cube_rows[z][y] = '0;
                end
                cube_rows[0][0][0] = 1'b1;
                batch.push_back(make_beat(KIND_NOTICE, 0, 0, 0, 1'b0));
                layer_model = 0;
            end
            OP_READ:
            begin
                batch.push_back(make_beat(KIND_READ, 0, 0, 0,
                    cube_rows[it.cell_z % SIDE][it.cell_y % SIDE][it.cell_x % SIDE]));
            end
            default:
            begin
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_beats.push_back(batch[i]);
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [1:0] got, logic [1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Offers one item and waits until it is taken; bursts and gaps are chosen here.
    task automatic send_item(logic [1:0] op, int unsigned x, int unsigned y, int unsigned z);
        item_t it;
        int    gap;
        it.op     = op;
        it.cell_x = x[4:0];
        it.cell_y = y[4:0];
        it.cell_z = z[4:0];
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        predict_item(it);
        if (gap_max > 0 && burst_left == 0)
        begin
            gap        = $urandom_range(gap_max, 1);
            burst_left = $urandom_range(8, 0);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else if (burst_left > 0)
        begin
            burst_left--;
        end
    endtask

    task automatic hold_items();
        item_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stops offering items until every predicted beat has come out.
    task automatic wait_for_results();
        hold_items();
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rule(logic [31:0] value);
        wait_for_results();
        rule_we   <= 1'b1;
        rule_data <= value;
        @(posedge clk);
        rule_model = value;
        rule_we   <= 1'b0;
    endtask

    // Receiver stall pattern, with a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = LONG_HOLD - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            case (stall_style)
                STALL_RANDOM:
                    result_stall <= ($urandom_range(3, 0) == 0);
                STALL_RUNS:
                begin
                    if (run_left == 0)
                    begin
                        run_stalling = !run_stalling;
                        run_left = run_stalling ? $urandom_range(6, 1) : $urandom_range(12, 1);
                    end
                    run_left = run_left - 1;
                    result_stall <= run_stalling;
                end
                default:
                    result_stall <= 1'b0;
            endcase
        end
    end

    // Each result beat is compared with the oldest prediction.
    always @(posedge clk)
    begin : check_beat
        result_t want;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (expected_beats.size() == 0)
            begin
                report_mismatch($sformatf("result beat %p with nothing expected", result));
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("kind", result.kind, want.kind);
                check_field("chunk_x", result.chunk_x, want.chunk_x);
                check_field("chunk_y", result.chunk_y, want.chunk_y);
                check_field("chunk_z", result.chunk_z, want.chunk_z);
                check_field("cell_value", result.cell_value, want.cell_value);
                check_field("last", result.last, want.last);
            end
        end
    end

    // Cube as left by reset, with the rule word still at its reset value.
    task automatic test_reset_contents();
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_READ, 31, 31, 31);
        send_item(OP_READ, 31, 0, 0);
        send_item(OP_READ, 0, 31, 0);
        send_item(OP_READ, 0, 0, 31);
        send_item(OP_UNUSED, 31, 31, 31);
        send_item(OP_STEP, 31, 31, 31);
    endtask

    // All-ones rule fills whole layers; all-zeros rule empties them again.
    task automatic test_rule_extremes();
        write_rule(32'hFFFF_FFFF);
        send_item(OP_STEP, 0, 0, 0);
        send_item(OP_READ, 5, 9, 2);
        send_item(OP_STEP, 0, 0, 0);
        write_rule(32'h0000_0000);
        send_item(OP_STEP, 0, 0, 0);
        send_item(OP_STEP, 0, 0, 0);
        send_item(OP_READ, 0, 0, 3);
    endtask

    // Clear of a busy cube, then of a cube holding the origin cell only.
    task automatic test_clear_volume();
        send_item(OP_CLEAR, 31, 31, 31);
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_READ, 3, 3, 2);
        send_item(OP_CLEAR, 0, 0, 0);
    endtask

    // Growth from the origin wraps around the cube in x and y.
    task automatic test_growth();
        write_rule(32'hFFFF_FFFE);
        repeat (4) send_item(OP_STEP, 0, 0, 0);
        send_item(OP_READ, 31, 0, 4);
        send_item(OP_READ, 0, 30, 4);
    endtask

    // The receiver holds off while items keep coming, so the block backs up.
    task automatic test_backpressure();
        stall_style = STALL_NONE;
        gap_max     = 0;
        hold_req    = !hold_req;
        repeat (6) send_item(OP_STEP, $urandom_range(31, 0), 0, 0);
        send_item(OP_READ, $urandom_range(31, 0), $urandom_range(31, 0), layer_model);
        send_item(OP_STEP, 0, 0, 0);
        wait_for_results();
    endtask

    // Random ops under several rule words and pacing styles.
    task automatic test_random_mix();
        logic [31:0] rule_choice;
        int          pick;
        int unsigned zr;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1:       rule_choice = 32'hFFFF_FFFE;
                3:       rule_choice = 32'h0000_0001;
                default: rule_choice = $urandom();
            endcase
            write_rule(rule_choice);
            case (phase % 3)
                0:       stall_style = STALL_RANDOM;
                1:       stall_style = STALL_RUNS;
                default: stall_style = STALL_NONE;
            endcase
            gap_max    = (phase == 2) ? 0 : $urandom_range(6, 1);
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99, 0);
                zr = ($urandom_range(1, 0) == 1) ? layer_model : $urandom_range(31, 0);
                if (pick < 55)
                    send_item(OP_STEP, $urandom_range(31, 0), $urandom_range(31, 0),
                              $urandom_range(31, 0));
                else if (pick < 87)
                    send_item(OP_READ, $urandom_range(31, 0), $urandom_range(31, 0), zr);
                else if (pick < 94)
                    send_item(OP_CLEAR, $urandom_range(31, 0), $urandom_range(31, 0),
                              $urandom_range(31, 0));
                else
                    send_item(OP_UNUSED, $urandom_range(31, 0), $urandom_range(31, 0),
                              $urandom_range(31, 0));
            end
        end
    endtask

    initial
    begin
        cube_rows[0][0][0] = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_contents();
        test_rule_extremes();
        test_clear_volume();
        test_growth();
        test_backpressure();
        test_random_mix();
        wait_for_results();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog against a block that hangs.
    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
